// File: hdl/local_interrupt_timer_assert.svh
// Assertion macros for the local interrupt timer.
`ifndef LOCAL_INTERRUPT_TIMER_ASSERT_SVH
`define LOCAL_INTERRUPT_TIMER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define LIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define LIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/lit_pkg.sv
// Types and constants shared by the local interrupt timer modules.
`default_nettype none

package lit_pkg;

    localparam int DATA_BITS = 32;
    localparam int VEC_BITS  = 8;
    localparam int MODE_BITS = 2;
    localparam int DIV_BITS  = 4;
    localparam int PRE_BITS  = 7;
    localparam int MASK_POS  = 16;
    localparam int MODE_POS  = 17;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] SEL_ENTRY   = 2'd0;
    localparam logic [1:0] SEL_INITIAL = 2'd1;
    localparam logic [1:0] SEL_CURRENT = 2'd2;
    localparam logic [1:0] SEL_DIVIDE  = 2'd3;

    localparam logic [MODE_BITS-1:0] MODE_PERIODIC = 2'd1;

    typedef struct packed {
        logic step;
        logic clear;
    } t_pre_ctl;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic                 irq_fire;
        logic [VEC_BITS-1:0]  irq_vector;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/lit_prescaler.sv
// Clock prescaler: divides ticks by a power of two chosen by the divide code.
`default_nettype none

module lit_prescaler import lit_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_pre_ctl           i_ctl,
    input  wire [DIV_BITS-1:0] i_divide_code,
    output logic               o_divided
);

    logic [PRE_BITS-1:0] r_prescale;
    logic [PRE_BITS-1:0] n_prescale;
    logic [2:0]          shift;
    logic [PRE_BITS-1:0] limit;

    always_comb begin
        shift      = {i_divide_code[3], i_divide_code[1:0]} + 3'd1;
        limit      = PRE_BITS'((8'd1 << shift) - 8'd1);
        o_divided  = i_ctl.step && (r_prescale >= limit);
        n_prescale = r_prescale;
        if (i_ctl.clear) begin
            n_prescale = '0;
        end else if (i_ctl.step) begin
            n_prescale = o_divided ? '0 : r_prescale + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
        end else begin
            r_prescale <= n_prescale;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lit_core.sv
// Timer registers, count-down logic and register read decode.
`default_nettype none

module lit_core import lit_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire [1:0]           i_command,
    input  wire [1:0]           i_reg_select,
    input  wire [DATA_BITS-1:0] i_write_data,
    output t_result             o_result
);

    logic [VEC_BITS-1:0]   r_vector;
    logic                  r_mask;
    logic [MODE_BITS-1:0]  r_mode;
    logic [COUNT_BITS-1:0] r_reload;
    logic [COUNT_BITS-1:0] r_count;
    logic [DIV_BITS-1:0]   r_divide;

    logic [VEC_BITS-1:0]   n_vector;
    logic                  n_mask;
    logic [MODE_BITS-1:0]  n_mode;
    logic [COUNT_BITS-1:0] n_reload;
    logic [COUNT_BITS-1:0] n_count;
    logic [DIV_BITS-1:0]   n_divide;

    t_pre_ctl              pre_ctl;
    logic                  divided;
    logic [COUNT_BITS-1:0] count_dec;

    lit_prescaler u_prescaler (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (pre_ctl),
        .i_divide_code (r_divide),
        .o_divided     (divided)
    );

    always_comb begin
        pre_ctl.step  = i_accept && (i_command == CMD_TICK);
        pre_ctl.clear = i_accept && (i_command == CMD_WRITE) &&
                        (i_reg_select == SEL_INITIAL);
    end

    always_comb begin
        n_vector  = r_vector;
        n_mask    = r_mask;
        n_mode    = r_mode;
        n_reload  = r_reload;
        n_count   = r_count;
        n_divide  = r_divide;
        count_dec = r_count - 1'b1;
        o_result  = '0;
        unique case (i_command)
            CMD_TICK: begin
                if (divided && (r_count != '0)) begin
                    n_count = count_dec;
                    if (count_dec == '0) begin
                        if (r_mode == MODE_PERIODIC) begin
                            n_count = r_reload;
                        end
                        if (!r_mask) begin
                            o_result.irq_fire   = 1'b1;
                            o_result.irq_vector = r_vector;
                        end
                    end
                end
            end
            CMD_WRITE: begin
                unique case (i_reg_select)
                    SEL_ENTRY: begin
                        n_vector = i_write_data[VEC_BITS-1:0];
                        n_mask   = i_write_data[MASK_POS];
                        n_mode   = i_write_data[MODE_POS +: MODE_BITS];
                    end
                    SEL_INITIAL: begin
                        n_reload = COUNT_BITS'(i_write_data);
                        n_count  = COUNT_BITS'(i_write_data);
                    end
                    SEL_DIVIDE: begin
                        n_divide = i_write_data[DIV_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            CMD_READ: begin
                unique case (i_reg_select)
                    SEL_ENTRY: begin
                        o_result.read_data = DATA_BITS'({r_mode, r_mask, 8'd0, r_vector});
                    end
                    SEL_INITIAL: o_result.read_data = DATA_BITS'(r_reload);
                    SEL_CURRENT: o_result.read_data = DATA_BITS'(r_count);
                    SEL_DIVIDE:  o_result.read_data = DATA_BITS'(r_divide);
                    default:     o_result.read_data = '0;
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector <= '0;
            r_mask   <= 1'b1;
            r_mode   <= '0;
            r_reload <= '0;
            r_count  <= '0;
            r_divide <= '0;
        end else if (i_accept) begin
            r_vector <= n_vector;
            r_mask   <= n_mask;
            r_mode   <= n_mode;
            r_reload <= n_reload;
            r_count  <= n_count;
            r_divide <= n_divide;
        end
    end

endmodule

`default_nettype wire

// File: hdl/local_interrupt_timer.sv
// Local interrupt timer top level: item handshake and result register.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+------------------------------------
//   in       | input     | i_in_valid / o_in_ready  | i_command, i_reg_select, i_write_data
//   out      | output    | o_out_valid / i_out_ready| o_read_data, o_irq_fire, o_irq_vector
//
// One item per cycle while the result is not stalled; each item's result is in the result
// register in the cycle after it is accepted, set by the single decode/count-down pass.
// Synchronous active-low reset; the entry comes up masked, counts at zero.
// A stalled result holds; a new item is taken whenever the result register
// is empty or is being emptied in the same cycle.
`default_nettype none

module local_interrupt_timer import lit_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire [1:0]            i_command,
    input  wire [1:0]            i_reg_select,
    input  wire [DATA_BITS-1:0]  i_write_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [DATA_BITS-1:0] o_read_data,
    output logic                 o_irq_fire,
    output logic [VEC_BITS-1:0]  o_irq_vector
);

`include "local_interrupt_timer_assert.svh"

    logic    accept;
    t_result result;
    t_result r_result;
    logic    r_out_valid;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    lit_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_command),
        .i_reg_select (i_reg_select),
        .i_write_data (i_write_data),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_result.read_data;
    assign o_irq_fire   = r_result.irq_fire;
    assign o_irq_vector = r_result.irq_vector;

    `LIT_ASSERT_NEXT(a_accept_gives_result, accept, r_out_valid, "accepted item left no result")
    `LIT_ASSERT_NOW(a_vector_only_on_fire, r_out_valid && !r_result.irq_fire,
        r_result.irq_vector == '0, "vector set without interrupt")
    `LIT_ASSERT_NOW(a_fire_only_on_tick, r_out_valid && r_result.irq_fire,
        r_result.read_data == '0, "interrupt on a read result")
    `LIT_ASSERT_NEXT(a_stall_holds, r_out_valid && !i_out_ready,
        r_out_valid && $stable(r_result), "stalled result changed")

endmodule

`default_nettype wire

// File: tb/tb_local_interrupt_timer.sv
// Testbench for local_interrupt_timer: random ticks and register traffic, checked item by item.
`timescale 1ns / 1ps

module tb_local_interrupt_timer;
    import lit_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [MODE_BITS-1:0] MODE_ONESHOT  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_DEADLINE = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_RESERVED = 2'd3;

    localparam logic [DIV_BITS-1:0] DIV_BY_1   = 4'hB;
    localparam logic [DIV_BITS-1:0] DIV_BY_2   = 4'h0;
    localparam logic [DIV_BITS-1:0] DIV_BY_4   = 4'h1;
    localparam logic [DIV_BITS-1:0] DIV_BY_32  = 4'h8;
    localparam logic [DIV_BITS-1:0] DIV_BY_128 = 4'hA;

    localparam int RANDOM_OPS  = 1280;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 10;
    localparam int MAX_LINES   = 100;

    typedef struct {
        logic [1:0]           cmd;
        logic [1:0]           sel;
        logic [DATA_BITS-1:0] data;
        int                   gap;
    } t_timer_op;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           command = CMD_TICK;
    logic [1:0]           reg_select = SEL_ENTRY;
    logic [DATA_BITS-1:0] write_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [DATA_BITS-1:0] read_data;
    logic                 irq_fire;
    logic [VEC_BITS-1:0]  irq_vector;

    // timer state as the testbench sees it
    logic [VEC_BITS-1:0]  tm_vector;
    logic                 tm_mask;
    logic [MODE_BITS-1:0] tm_mode;
    logic [DATA_BITS-1:0] tm_reload;
    logic [DATA_BITS-1:0] tm_count;
    logic [DIV_BITS-1:0]  tm_div_code;
    logic [PRE_BITS-1:0]  tm_prescale;

    t_timer_op pending_ops[$];
    t_timer_op next_op;
    t_result   expected_results[$];
    t_result   want;

    int  errors = 0;
    int  cycles = 0;
    int  idle_cnt = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;

    local_interrupt_timer i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_command    (command),
        .i_reg_select (reg_select),
        .i_write_data (write_data),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_read_data  (read_data),
        .o_irq_fire   (irq_fire),
        .o_irq_vector (irq_vector)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [DATA_BITS-1:0] got,
                                   input logic [DATA_BITS-1:0] exp_val);
        if (errors < MAX_LINES)
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        errors++;
    endtask

    function automatic t_result timer_predict(input logic [1:0] cmd, input logic [1:0] sel,
                                              input logic [DATA_BITS-1:0] data);
        t_result    r;
        logic [2:0] shift;
        logic [7:0] divisor;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                shift   = {tm_div_code[3], tm_div_code[1:0]} + 3'd1;
                divisor = 8'd1 << shift;
                if ({1'b0, tm_prescale} >= divisor - 8'd1) begin
                    tm_prescale = '0;
                    if (tm_count != '0) begin
                        tm_count = tm_count - 1'b1;
                        if (tm_count == '0) begin
                            if (tm_mode == MODE_PERIODIC)
                                tm_count = tm_reload;
                            if (!tm_mask) begin
                                r.irq_fire   = 1'b1;
                                r.irq_vector = tm_vector;
                            end
                        end
                    end
                end else begin
                    tm_prescale = tm_prescale + 1'b1;
                end
            end
            CMD_WRITE: begin
                case (sel)
                    SEL_ENTRY: begin
                        tm_vector = data[VEC_BITS-1:0];
                        tm_mask   = data[MASK_POS];
                        tm_mode   = data[MODE_POS +: MODE_BITS];
                    end
                    SEL_INITIAL: begin
                        tm_reload   = data;
                        tm_count    = data;
                        tm_prescale = '0;
                    end
                    SEL_DIVIDE: tm_div_code = data[DIV_BITS-1:0];
                    default: ;
                endcase
            end
            CMD_READ: begin
                case (sel)
                    SEL_ENTRY:   r.read_data = DATA_BITS'(tm_vector)
                                             | (DATA_BITS'(tm_mask) << MASK_POS)
                                             | (DATA_BITS'(tm_mode) << MODE_POS);
                    SEL_INITIAL: r.read_data = tm_reload;
                    SEL_CURRENT: r.read_data = tm_count;
                    default:     r.read_data = DATA_BITS'(tm_div_code);
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_op(input logic [1:0] cmd, input logic [1:0] sel,
                          input logic [DATA_BITS-1:0] data);
        t_timer_op op;
        int        r;
        r = $urandom_range(0, 99);
        op.cmd  = cmd;
        op.sel  = sel;
        op.data = data;
        if (no_idle || r < 60)
            op.gap = 0;
        else if (r < 92)
            op.gap = $urandom_range(1, 3);
        else
            op.gap = $urandom_range(8, 30);
        pending_ops.push_back(op);
    endtask

    function automatic logic [DATA_BITS-1:0] entry_word(input logic [VEC_BITS-1:0] vec,
                                                        input logic msk,
                                                        input logic [MODE_BITS-1:0] mode,
                                                        input logic [DATA_BITS-1:0] filler);
        logic [DATA_BITS-1:0] w;
        w = filler;
        w[VEC_BITS-1:0] = vec;
        w[MASK_POS] = msk;
        w[MODE_POS +: MODE_BITS] = mode;
        return w;
    endfunction

    // driver and predictor
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            idle_cnt = 0;
        end else begin
            if (in_valid && in_ready)
                expected_results.push_back(timer_predict(command, reg_select, write_data));
            if (!in_valid || in_ready) begin
                if (pending_ops.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (idle_cnt < pending_ops[0].gap) begin
                    idle_cnt++;
                    in_valid <= 1'b0;
                end else begin
                    next_op = pending_ops.pop_front();
                    idle_cnt = 0;
                    in_valid   <= 1'b1;
                    command    <= next_op.cmd;
                    reg_select <= next_op.sel;
                    write_data <= next_op.data;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, read_data", read_data, '0);
            end else begin
                want = expected_results.pop_front();
                if (read_data !== want.read_data)
                    report_mismatch("read_data", read_data, want.read_data);
                if (irq_fire !== want.irq_fire)
                    report_mismatch("irq_fire", DATA_BITS'(irq_fire), DATA_BITS'(want.irq_fire));
                if (irq_vector !== want.irq_vector)
                    report_mismatch("irq_vector", DATA_BITS'(irq_vector),
                                    DATA_BITS'(want.irq_vector));
            end
        end
        if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if ((cycles / 700) % 4 == 0 || $urandom_range(0, 99) < 70) begin
            out_ready <= 1'b1;
        end else begin
            stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                       : $urandom_range(10, 40);
            out_ready <= 1'b0;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int                   r;
        int                   pick;
        logic [DATA_BITS-1:0] d;

        tm_vector   = '0;
        tm_mask     = 1'b1;
        tm_mode     = MODE_ONESHOT;
        tm_reload   = '0;
        tm_count    = '0;
        tm_div_code = DIV_BY_2;
        tm_prescale = '0;

        // directed: reset values, periodic reload, read-only count, odd modes, extremes
        add_op(CMD_READ,  SEL_ENTRY,   32'hFFFF_FFFF);
        add_op(CMD_READ,  SEL_DIVIDE,  '0);
        add_op(CMD_WRITE, SEL_DIVIDE,  {28'hFFF_FFFF, DIV_BY_1});
        add_op(CMD_WRITE, SEL_ENTRY,   entry_word(8'hFF, 1'b0, MODE_PERIODIC, 32'hFFFF_FFFF));
        add_op(CMD_WRITE, SEL_INITIAL, 32'd2);
        add_op(CMD_TICK,  SEL_DIVIDE,  32'hFFFF_FFFF);
        add_op(CMD_TICK,  SEL_ENTRY,   '0);
        add_op(CMD_READ,  SEL_CURRENT, '0);
        add_op(CMD_TICK,  SEL_ENTRY,   '0);
        add_op(CMD_TICK,  SEL_ENTRY,   '0);
        add_op(CMD_WRITE, SEL_CURRENT, 32'hFFFF_FFFF);
        add_op(CMD_READ,  SEL_CURRENT, '0);
        add_op(CMD_WRITE, SEL_ENTRY,   entry_word(8'h12, 1'b0, MODE_DEADLINE, '0));
        add_op(CMD_WRITE, SEL_INITIAL, 32'd1);
        add_op(CMD_TICK,  SEL_ENTRY,   '0);
        add_op(CMD_TICK,  SEL_ENTRY,   '0);
        add_op(CMD_READ,  SEL_CURRENT, '0);
        add_op(CMD_WRITE, SEL_ENTRY,   entry_word(8'h34, 1'b1, MODE_RESERVED, '0));
        add_op(CMD_WRITE, SEL_INITIAL, 32'hFFFF_FFFF);
        add_op(CMD_TICK,  SEL_ENTRY,   '0);
        add_op(CMD_READ,  SEL_CURRENT, '0);
        add_op(CMD_READ,  SEL_INITIAL, '0);
        add_op(CMD_WRITE, SEL_DIVIDE,  {28'h0, DIV_BY_128});
        add_op(CMD_NONE,  SEL_DIVIDE,  32'hFFFF_FFFF);
        add_op(CMD_READ,  SEL_ENTRY,   '0);

        for (int i = 0; i < RANDOM_OPS; i++) begin
            no_idle = ((i / 150) % 3 == 1);
            r = $urandom_range(0, 99);
            d = $urandom;
            if (r < 68) begin
                add_op(CMD_TICK, 2'($urandom_range(0, 3)), d);
            end else if (r < 82) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 8)
                        d = $urandom_range(1, 24);
                    else if (pick < 9)
                        d = '0;
                    add_op(CMD_WRITE, SEL_INITIAL, d);
                end else if (pick < 65) begin
                    if ($urandom_range(0, 3) != 0)
                        d[MASK_POS] = 1'b0;
                    if ($urandom_range(0, 1) != 0)
                        d[MODE_POS +: MODE_BITS] = MODE_PERIODIC;
                    add_op(CMD_WRITE, SEL_ENTRY, d);
                end else if (pick < 90) begin
                    if ($urandom_range(0, 1) != 0) begin
                        case ($urandom_range(0, 3))
                            0: d[DIV_BITS-1:0] = DIV_BY_1;
                            1: d[DIV_BITS-1:0] = DIV_BY_2;
                            2: d[DIV_BITS-1:0] = DIV_BY_4;
                            default: d[DIV_BITS-1:0] = DIV_BY_32;
                        endcase
                    end
                    add_op(CMD_WRITE, SEL_DIVIDE, d);
                end else begin
                    add_op(CMD_WRITE, SEL_CURRENT, d);
                end
            end else if (r < 96) begin
                add_op(CMD_READ, 2'($urandom_range(0, 3)), d);
            end else begin
                add_op(CMD_NONE, 2'($urandom_range(0, 3)), d);
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (expected_results.size() != 0)
            report_mismatch("results left over, count", expected_results.size(), '0);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
